@@ sv/dasc_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and helpers for the dual ADC sample calibration unit.
// Used by dasc_lane and dual_adc_sample_calibrate_unit; depends on nothing else.
package dasc_pkg;

  localparam int unsigned CodeW    = 12;
  localparam int unsigned RawW     = 2 * CodeW;
  localparam int unsigned OffsetW  = 12;
  localparam int unsigned ScaleW   = 13;
  localparam int unsigned RangeW   = 2;
  localparam int unsigned SampleW  = 36;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 13;
  localparam int unsigned MagW     = 24;
  localparam int unsigned QuantW   = 11;
  // Input register, one stage per quotient bit, then the range multiply.
  localparam int unsigned LaneDepth = MagW + 2;

  localparam logic [CodeW-1:0]  MidCode = 12'd2048;
  localparam logic [11:0]       SpanNom = 12'd3900;
  localparam logic [ScaleW-1:0] ScaleRst = 13'd3900;

  localparam logic [CfgIdxW-1:0] RegOffsetA = 3'd0;
  localparam logic [CfgIdxW-1:0] RegOffsetB = 3'd1;
  localparam logic [CfgIdxW-1:0] RegScaleA  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegScaleB  = 3'd3;
  localparam logic [CfgIdxW-1:0] RegRangeA  = 3'd4;
  localparam logic [CfgIdxW-1:0] RegRangeB  = 3'd5;
  localparam logic [CfgIdxW-1:0] RegCorrEn  = 3'd6;

  function automatic logic [QuantW-1:0] range_quantum(input logic [RangeW-1:0] rng);
    logic [QuantW-1:0] q;
    case (rng)
      2'd0:    q = 11'd2000;
      2'd1:    q = 11'd1000;
      2'd2:    q = 11'd500;
      default: q = 11'd250;
    endcase
    return q;
  endfunction

endpackage

@@ sv/dual_adc_sample_calibrate_unit.sv @@
`timescale 1ns / 1ps
// Top level of the dual ADC sample calibration unit: registers, two lanes,
// valid tracking and output skid stage. Depends on dasc_pkg and dasc_lane.
//
// Usage: each request on the s_axis side carries one 24-bit word with the
// channel A code in bits 11:0 and channel B in bits 23:12. Each produces one
// request on the m_axis side with both converted 36-bit samples.
// Registers are written through cfg_we_i/cfg_idx_i/cfg_data_i; the user must
// write them only while idle; the block does not enforce this. Both channels
// run in parallel lanes; each lane centers the code, forms the corrected
// product, divides it by the scale in a 24-stage pipelined restoring divider
// (one quotient bit per stage) and multiplies by the range quantum. Throughput
// is one word per cycle, set by the divider, unless the receiver stalls.
// When the receiver stalls, the output register holds and a skid register
// catches one more result; the pipeline then freezes and s_axis_tready
// drops until the skid register drains.
// Reset clears all valid flags and returns the registers to their defaults:
// offsets 0, scales 3900, ranges 0, correction off.
module dual_adc_sample_calibrate_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [12:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // raw_word[23:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata    // sample_a[35:0], sample_b[71:36]
);

  localparam int unsigned Depth = dasc_pkg::LaneDepth;
  localparam int unsigned SW = dasc_pkg::SampleW;

  logic signed [11:0] offset_a_q, offset_b_q;
  logic signed [12:0] scale_a_q, scale_b_q;
  logic [1:0]         range_a_q, range_b_q;
  logic               corr_en_q;
  logic               corr;

  logic [Depth-1:0] vld_q;
  logic             en;
  logic signed [SW-1:0] lane_a, lane_b;
  logic [2*SW-1:0]  out_q, skid_q;
  logic             out_vld_q, skid_vld_q;
  logic             out_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_a_q <= '0;
      offset_b_q <= '0;
      scale_a_q  <= dasc_pkg::ScaleRst;
      scale_b_q  <= dasc_pkg::ScaleRst;
      range_a_q  <= '0;
      range_b_q  <= '0;
      corr_en_q  <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        dasc_pkg::RegOffsetA: offset_a_q <= cfg_data_i[11:0];
        dasc_pkg::RegOffsetB: offset_b_q <= cfg_data_i[11:0];
        dasc_pkg::RegScaleA:  scale_a_q  <= cfg_data_i;
        dasc_pkg::RegScaleB:  scale_b_q  <= cfg_data_i;
        dasc_pkg::RegRangeA:  range_a_q  <= cfg_data_i[1:0];
        dasc_pkg::RegRangeB:  range_b_q  <= cfg_data_i[1:0];
        dasc_pkg::RegCorrEn:  corr_en_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // A zero scale on either channel turns correction off for both.
  assign corr = corr_en_q && (scale_a_q != '0) && (scale_b_q != '0);

  assign en = !skid_vld_q;
  assign s_axis_tready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Depth-2:0], s_axis_tvalid};
    end
  end

  dasc_lane u_lane_a (
    .clk_i    (clk_i),
    .en_i     (en),
    .code_i   (s_axis_tdata[11:0]),
    .offset_i (offset_a_q),
    .scale_i  (scale_a_q),
    .range_i  (range_a_q),
    .corr_i   (corr),
    .sample_o (lane_a)
  );

  dasc_lane u_lane_b (
    .clk_i    (clk_i),
    .en_i     (en),
    .code_i   (s_axis_tdata[23:12]),
    .offset_i (offset_b_q),
    .scale_i  (scale_b_q),
    .range_i  (range_b_q),
    .corr_i   (corr),
    .sample_o (lane_b)
  );

  assign out_load = !out_vld_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      if (out_load) begin
        out_vld_q <= skid_vld_q || (en && vld_q[Depth-1]);
        if (skid_vld_q) begin
          skid_vld_q <= 1'b0;
        end
      end else if (en && vld_q[Depth-1]) begin
        skid_vld_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= skid_vld_q ? skid_q : {lane_b, lane_a};
    end else if (en && vld_q[Depth-1]) begin
      skid_q <= {lane_b, lane_a};
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;

endmodule

@@ sv/dasc_lane.sv @@
`timescale 1ns / 1ps
// One channel of the converter: centering, correction product, pipelined
// restoring divider and range multiply. Depends on dasc_pkg.
module dasc_lane (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  logic [dasc_pkg::CodeW-1:0]          code_i,
  input  logic signed [dasc_pkg::OffsetW-1:0] offset_i,
  input  logic signed [dasc_pkg::ScaleW-1:0]  scale_i,
  input  logic [dasc_pkg::RangeW-1:0]         range_i,
  input  logic                                corr_i,
  output logic signed [dasc_pkg::SampleW-1:0] sample_o
);

  localparam int unsigned MagW = dasc_pkg::MagW;
  localparam int unsigned ScaleW = dasc_pkg::ScaleW;

  logic signed [12:0] center;
  logic signed [13:0] diff;
  logic signed [25:0] prod;
  logic [25:0]        prod_abs;

  // Per-stage divider state; entry 0 is the input register.
  logic [MagW-1:0]   num_q [0:MagW];
  logic [MagW-1:0]   quo_q [0:MagW];
  logic [ScaleW-1:0] rem_q [0:MagW];
  logic [ScaleW-1:0] div_q [0:MagW];
  logic              neg_q [0:MagW];
  logic              corr_q [0:MagW];
  logic signed [12:0] raw_q [0:MagW];

  logic [MagW-1:0]   num_d [1:MagW];
  logic [MagW-1:0]   quo_d [1:MagW];
  logic [ScaleW-1:0] rem_d [1:MagW];

  logic signed [24:0] qsigned;
  logic signed [24:0] sel;
  logic signed [36:0] scaled;
  logic signed [dasc_pkg::SampleW-1:0] sample_q;

  assign center   = $signed({1'b0, code_i}) - $signed({1'b0, dasc_pkg::MidCode});
  assign diff     = 14'(center) - 14'(offset_i);
  assign prod     = 26'(diff) * $signed({14'd0, dasc_pkg::SpanNom});
  assign prod_abs = prod[25] ? (26'd0 - prod) : prod;

  always_comb begin
    logic [ScaleW:0] trial;
    for (int k = 0; k < MagW; k++) begin
      trial = {rem_q[k], num_q[k][MagW-1]};
      if (trial >= {1'b0, div_q[k]}) begin
        rem_d[k+1] = ScaleW'(trial - {1'b0, div_q[k]});
        quo_d[k+1] = {quo_q[k][MagW-2:0], 1'b1};
      end else begin
        rem_d[k+1] = trial[ScaleW-1:0];
        quo_d[k+1] = {quo_q[k][MagW-2:0], 1'b0};
      end
      num_d[k+1] = {num_q[k][MagW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_q[0]  <= prod_abs[MagW-1:0];
      quo_q[0]  <= '0;
      rem_q[0]  <= '0;
      div_q[0]  <= scale_i[ScaleW-1] ? ScaleW'(-scale_i) : scale_i;
      neg_q[0]  <= prod[25] ^ scale_i[ScaleW-1];
      corr_q[0] <= corr_i;
      raw_q[0]  <= center;
      for (int k = 1; k <= MagW; k++) begin
        num_q[k]  <= num_d[k];
        quo_q[k]  <= quo_d[k];
        rem_q[k]  <= rem_d[k];
        div_q[k]  <= div_q[k-1];
        neg_q[k]  <= neg_q[k-1];
        corr_q[k] <= corr_q[k-1];
        raw_q[k]  <= raw_q[k-1];
      end
      sample_q <= scaled[dasc_pkg::SampleW-1:0];
    end
  end

  assign qsigned = neg_q[MagW] ? (25'sd0 - $signed({1'b0, quo_q[MagW]}))
                               : $signed({1'b0, quo_q[MagW]});
  assign sel     = corr_q[MagW] ? qsigned : 25'(raw_q[MagW]);
  assign scaled  = 37'(sel) * $signed({26'd0, dasc_pkg::range_quantum(range_i)});
  assign sample_o = sample_q;

endmodule
